// ===== sv/hnpcs_pkg.sv =====
package hnpcs_pkg;

   typedef struct packed {
      logic [1:0]  command;
      logic [15:0] cell_x;
      logic [15:0] cell_y;
      logic [15:0] hint_index;
   } req_type;

   typedef struct packed {
      logic [9:0] nearest_index;
      logic       list_empty;
      logic       right_side;
   } rsp_type;

   localparam int RSP_INDEX_BITS = 10;

   localparam logic [1:0] CMD_CLEAR  = 2'd0;
   localparam logic [1:0] CMD_APPEND = 2'd1;
   localparam logic [1:0] CMD_QUERY  = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ISS_HINT,
      ST_ISS_NEXT,
      ST_ISS_PREV,
      ST_PRIME_WAIT,
      ST_WALK_START,
      ST_WALK,
      ST_DRAIN,
      ST_CHORD_LO,
      ST_CHORD_HI,
      ST_CHORD_WAIT,
      ST_DONE
   } state_type;

   // what the read port fetches this cycle; travels down the pipe as a tag
   typedef enum logic [2:0] {
      RD_NONE,
      RD_HINT,
      RD_NEXT,
      RD_PREV,
      RD_WALK,
      RD_LO,
      RD_HI
   } rd_sel_type;

   typedef struct packed {
      logic       take;
      rd_sel_type rd_sel;
      logic       start_walk;
      logic       load_rsp;
   } dp_cmd_type;

   typedef struct packed {
      logic count_zero;
      logic has_next;
      logic has_prev;
      logic walk_end;
      logic stop;
      logic pipe_busy;
      logic cross_done;
   } dp_status_type;

endpackage

// ===== sv/hnpcs_ram.sv =====
module hnpcs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/hnpcs_ctrl.sv =====
module hnpcs_ctrl
   import hnpcs_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic [1:0]    req_command,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_command == CMD_QUERY) begin
               state_in = status.count_zero ? ST_DONE : ST_ISS_HINT;
            end
         end
         ST_ISS_HINT:   state_in = ST_ISS_NEXT;
         ST_ISS_NEXT:   state_in = ST_ISS_PREV;
         ST_ISS_PREV:   state_in = ST_PRIME_WAIT;
         ST_PRIME_WAIT: begin
            if (!status.pipe_busy) begin
               state_in = ST_WALK_START;
            end
         end
         ST_WALK_START: state_in = ST_WALK;
         ST_WALK: begin
            if (status.stop || status.walk_end) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = ST_CHORD_LO;
            end
         end
         ST_CHORD_LO:   state_in = ST_CHORD_HI;
         ST_CHORD_HI:   state_in = ST_CHORD_WAIT;
         ST_CHORD_WAIT: begin
            if (status.cross_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd            = '0;
      cmd.rd_sel     = RD_NONE;
      req_ready      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.take  = req_valid;
         end
         ST_ISS_HINT: cmd.rd_sel = RD_HINT;
         ST_ISS_NEXT: cmd.rd_sel = status.has_next ? RD_NEXT : RD_NONE;
         ST_ISS_PREV: cmd.rd_sel = status.has_prev ? RD_PREV : RD_NONE;
         ST_WALK_START: cmd.start_walk = 1'b1;
         ST_WALK: begin
            // keep fetching until the far end or a stop; late fetches are dropped
            cmd.rd_sel = (status.stop || status.walk_end) ? RD_NONE : RD_WALK;
         end
         ST_CHORD_LO: cmd.rd_sel   = RD_LO;
         ST_CHORD_HI: cmd.rd_sel   = RD_HI;
         ST_DONE:     cmd.load_rsp = slot_free;
         default: begin
            cmd.rd_sel = RD_NONE;
         end
      endcase
      rsp_valid_in = cmd.load_rsp || (rsp_valid_ff && !rsp_ready);
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== sv/hnpcs_dp.sv =====
module hnpcs_dp
   import hnpcs_pkg::*;
#(
   parameter int LIST_DEPTH = 1024,
   parameter int COORD_BITS = 16,
   parameter int STOP_GAP   = 10,
   parameter int CHORD_STEP = 3
) (
   input  logic          clock,
   input  logic          reset,
   input  req_type       req_data,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   output rsp_type       rsp_data
);

   localparam int IDX_W  = $clog2(LIST_DEPTH);
   localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
   localparam int SQ_W   = 2 * COORD_BITS;
   localparam int DIST_W = 2 * COORD_BITS + 1;
   localparam int PROD_W = 2 * COORD_BITS + 2;
   localparam int CMP_W  = (CNT_W > 16) ? CNT_W : 16;
   localparam int GAP_W  = (IDX_W > 8) ? IDX_W : 8;
   localparam int SUM_W  = ((CNT_W > 7) ? CNT_W : 7) + 1;

   // list and query state
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [COORD_BITS-1:0]  qx_ff, qy_ff;
   logic [IDX_W-1:0]       hint_ff, hint_in;
   logic [IDX_W-1:0]       iss_ff;
   logic                   dir_down_ff;
   logic                   stop_ff;
   logic [DIST_W-1:0]      min_d_ff, next_d_ff, prev_d_ff;
   logic [IDX_W-1:0]       min_i_ff;

   // distance pipe
   rd_sel_type             sel_s1_ff, sel_s2_ff, sel_s3_ff, sel_s4_ff;
   logic [IDX_W-1:0]       idx_s1_ff, idx_s2_ff, idx_s3_ff, idx_s4_ff;
   logic [COORD_BITS-1:0]  dx_ff, dy_ff;
   logic [SQ_W-1:0]        sqx_ff, sqy_ff;
   logic [DIST_W-1:0]      dist_ff;

   // chord pipe
   logic [COORD_BITS-1:0]  ax_ff, ay_ff, bx_ff, by_ff;
   logic signed [COORD_BITS:0] ex_ff, ey_ff, fx_ff, fy_ff;
   logic signed [PROD_W-1:0]   p1_ff, p2_ff;
   logic                   ch_v1_ff, ch_v2_ff, ch_v3_ff, cross_done_ff;
   logic                   right_ff;
   rsp_type                rsp_ff;

   // memory port
   logic                   wr_en, rd_en;
   logic [IDX_W-1:0]       rd_addr, walk_addr, chord_lo, chord_hi;
   logic [2*COORD_BITS-1:0] wr_data, rd_data;
   logic [COORD_BITS-1:0]  rd_x, rd_y;

   logic                   has_next, has_prev, go_down, dist_le, is_dist_s1, walk_hit;
   logic [IDX_W-1:0]       gap;
   logic [SUM_W-1:0]       mi_w, st_w, cap_w, lo_w, hi_w, hi_c;

   assign wr_en   = cmd.take && req_data.command == CMD_APPEND
                    && count_ff != CNT_W'(LIST_DEPTH);
   assign wr_data = {COORD_BITS'(req_data.cell_x), COORD_BITS'(req_data.cell_y)};
   assign rd_en   = cmd.rd_sel != RD_NONE;
   assign rd_x    = rd_data[2*COORD_BITS-1:COORD_BITS];
   assign rd_y    = rd_data[COORD_BITS-1:0];

   hnpcs_ram #(
      .WIDTH (2 * COORD_BITS),
      .DEPTH (LIST_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign has_next  = (CNT_W'(hint_ff) + 1'b1) != count_ff;
   assign has_prev  = hint_ff != '0;
   assign go_down   = has_prev && (!has_next || prev_d_ff < next_d_ff);
   assign walk_addr = dir_down_ff ? iss_ff - 1'b1 : iss_ff + 1'b1;

   // chord ends, clamped to the list
   always_comb begin
      mi_w     = SUM_W'(min_i_ff);
      st_w     = SUM_W'(CHORD_STEP);
      cap_w    = SUM_W'(count_ff) - 1'b1;
      lo_w     = (mi_w >= st_w) ? mi_w - st_w : '0;
      hi_w     = mi_w + st_w;
      hi_c     = (hi_w > cap_w) ? cap_w : hi_w;
      chord_lo = lo_w[IDX_W-1:0];
      chord_hi = hi_c[IDX_W-1:0];
   end

   always_comb begin
      case (cmd.rd_sel)
         RD_HINT: rd_addr = hint_ff;
         RD_NEXT: rd_addr = hint_ff + 1'b1;
         RD_PREV: rd_addr = hint_ff - 1'b1;
         RD_WALK: rd_addr = walk_addr;
         RD_LO:   rd_addr = chord_lo;
         RD_HI:   rd_addr = chord_hi;
         default: rd_addr = hint_ff;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.take && req_data.command == CMD_CLEAR) begin
         count_in = '0;
      end else if (wr_en) begin
         count_in = count_ff + 1'b1;
      end
      if (CMP_W'(req_data.hint_index) >= CMP_W'(count_ff)) begin
         hint_in = IDX_W'(count_ff - 1'b1);
      end else begin
         hint_in = IDX_W'(req_data.hint_index);
      end
   end

   assign is_dist_s1 = sel_s1_ff inside {RD_HINT, RD_NEXT, RD_PREV, RD_WALK};
   assign dist_le    = dist_ff <= min_d_ff;
   assign gap        = dir_down_ff ? min_i_ff - idx_s4_ff : idx_s4_ff - min_i_ff;
   assign walk_hit   = sel_s4_ff == RD_WALK && !stop_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         sel_s1_ff     <= RD_NONE;
         sel_s2_ff     <= RD_NONE;
         sel_s3_ff     <= RD_NONE;
         sel_s4_ff     <= RD_NONE;
         stop_ff       <= 1'b0;
         ch_v1_ff      <= 1'b0;
         ch_v2_ff      <= 1'b0;
         ch_v3_ff      <= 1'b0;
         cross_done_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         sel_s1_ff     <= cmd.rd_sel;
         sel_s2_ff     <= is_dist_s1 ? sel_s1_ff : RD_NONE;
         sel_s3_ff     <= sel_s2_ff;
         sel_s4_ff     <= sel_s3_ff;
         ch_v1_ff      <= sel_s1_ff == RD_HI;
         ch_v2_ff      <= ch_v1_ff;
         ch_v3_ff      <= ch_v2_ff;
         cross_done_ff <= ch_v3_ff;
         if (cmd.start_walk) begin
            stop_ff <= 1'b0;
         end else if (walk_hit && !dist_le && GAP_W'(gap) > GAP_W'(STOP_GAP)) begin
            stop_ff <= 1'b1;
         end
      end
   end

   // datapath payload
   always_ff @(posedge clock) begin
      if (cmd.take && req_data.command == CMD_QUERY) begin
         qx_ff   <= COORD_BITS'(req_data.cell_x);
         qy_ff   <= COORD_BITS'(req_data.cell_y);
         hint_ff <= hint_in;
      end
      if (cmd.start_walk) begin
         dir_down_ff <= go_down;
         iss_ff      <= hint_ff;
      end else if (cmd.rd_sel == RD_WALK) begin
         iss_ff <= walk_addr;
      end

      idx_s1_ff <= rd_addr;
      idx_s2_ff <= idx_s1_ff;
      idx_s3_ff <= idx_s2_ff;
      idx_s4_ff <= idx_s3_ff;
      dx_ff     <= (rd_x > qx_ff) ? rd_x - qx_ff : qx_ff - rd_x;
      dy_ff     <= (rd_y > qy_ff) ? rd_y - qy_ff : qy_ff - rd_y;
      sqx_ff    <= SQ_W'(dx_ff) * SQ_W'(dx_ff);
      sqy_ff    <= SQ_W'(dy_ff) * SQ_W'(dy_ff);
      dist_ff   <= DIST_W'(sqx_ff) + DIST_W'(sqy_ff);

      case (sel_s4_ff)
         RD_HINT: begin
            min_d_ff <= dist_ff;
            min_i_ff <= hint_ff;
         end
         RD_NEXT: next_d_ff <= dist_ff;
         RD_PREV: prev_d_ff <= dist_ff;
         RD_WALK: begin
            // ties move the minimum along the walk
            if (!stop_ff && dist_le) begin
               min_d_ff <= dist_ff;
               min_i_ff <= idx_s4_ff;
            end
         end
         default: begin
            min_d_ff <= min_d_ff;
         end
      endcase

      if (sel_s1_ff == RD_LO) begin
         ax_ff <= rd_x;
         ay_ff <= rd_y;
      end
      if (sel_s1_ff == RD_HI) begin
         bx_ff <= rd_x;
         by_ff <= rd_y;
      end
      ex_ff <= $signed({1'b0, bx_ff}) - $signed({1'b0, ax_ff});
      ey_ff <= $signed({1'b0, by_ff}) - $signed({1'b0, ay_ff});
      fx_ff <= $signed({1'b0, qx_ff}) - $signed({1'b0, ax_ff});
      fy_ff <= $signed({1'b0, qy_ff}) - $signed({1'b0, ay_ff});
      p1_ff <= PROD_W'(ex_ff) * PROD_W'(fy_ff);
      p2_ff <= PROD_W'(ey_ff) * PROD_W'(fx_ff);
      if (ch_v3_ff) begin
         right_ff <= !(p1_ff > p2_ff);
      end

      if (cmd.load_rsp) begin
         rsp_ff.nearest_index <= status.count_zero ? '0 : RSP_INDEX_BITS'(min_i_ff);
         rsp_ff.list_empty    <= status.count_zero;
         rsp_ff.right_side    <= !status.count_zero && right_ff;
      end
   end

   always_comb begin
      status.count_zero = count_ff == '0;
      status.has_next   = has_next;
      status.has_prev   = has_prev;
      status.walk_end   = dir_down_ff ? (iss_ff == '0)
                                      : ((CNT_W'(iss_ff) + 1'b1) == count_ff);
      status.stop       = stop_ff;
      status.pipe_busy  = sel_s1_ff != RD_NONE || sel_s2_ff != RD_NONE
                          || sel_s3_ff != RD_NONE || sel_s4_ff != RD_NONE;
      status.cross_done = cross_done_ff;
   end

   assign rsp_data = rsp_ff;

endmodule

// ===== sv/hinted_nearest_path_cell_side_unit.sv =====
// Clear and append are taken in the idle state and may follow back to back.
// A query on an empty list answers without any memory read; otherwise the unit reads
// the hint cell and its neighbours, walks from the hint until the list end or a stop,
// then reads the chord ends (one fetch per cycle from the single read port of the path
// memory, plus a four-stage distance pipe and a five-stage chord pipe).
// One query is in work at a time. Reset clears the cell count and all control state.
module hinted_nearest_path_cell_side_unit
   import hnpcs_pkg::*;
#(
   parameter int LIST_DEPTH = 1024,
   parameter int COORD_BITS = 16,
   parameter int STOP_GAP   = 10,
   parameter int CHORD_STEP = 3
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   dp_cmd_type    cmd;
   dp_status_type status;

   hnpcs_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_data.command),
      .req_ready   (req_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .status      (status),
      .cmd         (cmd)
   );

   hnpcs_dp #(
      .LIST_DEPTH (LIST_DEPTH),
      .COORD_BITS (COORD_BITS),
      .STOP_GAP   (STOP_GAP),
      .CHORD_STEP (CHORD_STEP)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

// ===== sv/hnpcs_checker.sv =====
module hnpcs_checker
   import hnpcs_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_empty_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.list_empty |->
         rsp_data.nearest_index == '0 && !rsp_data.right_side)
      else $error("empty result carries index or side");

   // list edits never stall the next transfer
   a_edit_ready: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.command != CMD_QUERY |=> req_ready)
      else $error("not ready after list edit");

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.command == CMD_QUERY |=> !req_ready)
      else $error("ready while a query is in work");

endmodule

bind hinted_nearest_path_cell_side_unit hnpcs_checker u_checker (.*);

// ===== test/tb_top.sv =====
module tb_top;
   import hnpcs_pkg::*;

   localparam int LIST_DEPTH  = 1024;
   localparam int COORD_BITS  = 16;
   localparam int STOP_GAP    = 10;
   localparam int CHORD_STEP  = 3;
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 20_000_000;
   localparam int HOLD_CYCLES = 400;
   localparam int TAIL_CYCLES = 64;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   hinted_nearest_path_cell_side_unit #(
      .LIST_DEPTH(LIST_DEPTH),
      .COORD_BITS(COORD_BITS),
      .STOP_GAP  (STOP_GAP),
      .CHORD_STEP(CHORD_STEP)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   // path model
   logic [15:0] path_x [LIST_DEPTH];
   logic [15:0] path_y [LIST_DEPTH];
   int unsigned stored_cells = 0;
   rsp_type     expected_answers [$];
   rsp_type     oldest_answer;

   int  error_count   = 0;
   int  cycle_count   = 0;
   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   bit  hold_request  = 1'b0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic longint dist_sq(int unsigned i, logic [15:0] qx, logic [15:0] qy);
      longint dx, dy;
      dx = longint'(path_x[i]) - longint'(qx);
      dy = longint'(path_y[i]) - longint'(qy);
      return dx * dx + dy * dy;
   endfunction

   function automatic int unsigned walk_nearest(int unsigned hint, logic [15:0] qx,
                                                logic [15:0] qy);
      longint      best_d, prev_d, next_d, d;
      bit          has_prev, has_next, go_down, done;
      int unsigned best_i, n, gap;
      best_i   = hint;
      best_d   = dist_sq(hint, qx, qy);
      has_next = (hint + 1) < stored_cells;
      has_prev = hint > 0;
      prev_d   = 0;
      next_d   = 0;
      if (has_next) next_d = dist_sq(hint + 1, qx, qy);
      if (has_prev) prev_d = dist_sq(hint - 1, qx, qy);
      go_down = has_prev && (!has_next || prev_d < next_d);
      n    = hint;
      done = 1'b0;
      while (!done) begin
         if (go_down ? (n == 0) : (n + 1 >= stored_cells)) begin
            done = 1'b1;
         end else begin
            n = go_down ? n - 1 : n + 1;
            d = dist_sq(n, qx, qy);
            // ties move the minimum along
            if (d <= best_d) begin
               best_d = d;
               best_i = n;
            end else begin
               gap = (n > best_i) ? n - best_i : best_i - n;
               if (gap > STOP_GAP) done = 1'b1;
            end
         end
      end
      return best_i;
   endfunction

   function automatic bit chord_right(int unsigned idx, logic [15:0] qx, logic [15:0] qy);
      int unsigned lo, hi;
      longint      ax, ay, bx, by, p1, p2;
      hi = idx + CHORD_STEP;
      if (hi > stored_cells - 1) hi = stored_cells - 1;
      lo = (idx >= CHORD_STEP) ? idx - CHORD_STEP : 0;
      ax = longint'(path_x[lo]);
      ay = longint'(path_y[lo]);
      bx = longint'(path_x[hi]);
      by = longint'(path_y[hi]);
      p1 = (bx - ax) * (longint'(qy) - ay);
      p2 = (by - ay) * (longint'(qx) - ax);
      return !(p1 > p2);
   endfunction

   function automatic rsp_type answer_query(req_type r);
      rsp_type     res;
      int unsigned hint, idx;
      res = '0;
      if (stored_cells == 0) begin
         res.list_empty = 1'b1;
         return res;
      end
      hint = 32'(r.hint_index);
      if (hint > stored_cells - 1) hint = stored_cells - 1;
      idx = walk_nearest(hint, r.cell_x, r.cell_y);
      res.nearest_index = idx[RSP_INDEX_BITS-1:0];
      res.right_side    = chord_right(idx, r.cell_x, r.cell_y);
      return res;
   endfunction

   function automatic void update_path_model(req_type r);
      case (r.command)
         CMD_CLEAR: stored_cells = 0;
         CMD_APPEND: begin
            if (stored_cells < LIST_DEPTH) begin
               path_x[stored_cells] = r.cell_x;
               path_y[stored_cells] = r.cell_y;
               stored_cells++;
            end
         end
         CMD_QUERY: expected_answers.push_back(answer_query(r));
         default: ;
      endcase
   endfunction

   function automatic req_type pack_item(logic [1:0] cmd, logic [15:0] x, logic [15:0] y,
                                         logic [15:0] hint);
      req_type r;
      r.command    = cmd;
      r.cell_x     = x;
      r.cell_y     = y;
      r.hint_index = hint;
      return r;
   endfunction

   // query close to a stored cell, hint mostly around it, sometimes random
   function automatic req_type near_query();
      req_type     q;
      int unsigned k;
      int          h;
      k = $urandom_range(stored_cells - 1);
      q.command = CMD_QUERY;
      q.cell_x  = path_x[k] + 16'($urandom_range(16)) - 16'd8;
      q.cell_y  = path_y[k] + 16'($urandom_range(16)) - 16'd8;
      case ($urandom_range(9))
         0: q.hint_index = 16'($urandom);
         1: q.hint_index = 16'(k);
         default: begin
            h = int'(k) + int'($urandom_range(30)) - 15;
            if (h < 0) h = 0;
            q.hint_index = 16'(h);
         end
      endcase
      return q;
   endfunction

   // valid stays up across back-to-back transfers; it only drops for an idle gap
   task automatic offer_request(input req_type item);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      update_path_model(item);
   endtask

   task automatic drain_answers();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_answers.size() != 0) @(posedge clock);
   endtask

   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_answers.size() == 0) begin
            $error("unexpected result transfer: nearest_index %0d", rsp_data.nearest_index);
            error_count++;
         end else begin
            oldest_answer = expected_answers.pop_front();
            if (rsp_data.nearest_index !== oldest_answer.nearest_index) begin
               $error("nearest_index: expected %0d, actual %0d",
                      oldest_answer.nearest_index, rsp_data.nearest_index);
               error_count++;
            end
            if (rsp_data.list_empty !== oldest_answer.list_empty) begin
               $error("list_empty: expected %0d, actual %0d",
                      oldest_answer.list_empty, rsp_data.list_empty);
               error_count++;
            end
            if (rsp_data.right_side !== oldest_answer.right_side) begin
               $error("right_side: expected %0d, actual %0d",
                      oldest_answer.right_side, rsp_data.right_side);
               error_count++;
            end
         end
      end
   end

   task automatic test_directed();
      int k;
      offer_request(pack_item(CMD_QUERY, 16'hFFFF, 16'h0000, 16'hFFFF));   // empty list
      offer_request(pack_item(CMD_CLEAR, 16'h0000, 16'hFFFF, 16'h0000));
      offer_request(pack_item(CMD_APPEND, 16'h0000, 16'h0000, 16'hFFFF));
      offer_request(pack_item(CMD_QUERY, 16'hFFFF, 16'hFFFF, 16'hFFFF));   // single entry
      offer_request(pack_item(CMD_APPEND, 16'hFFFF, 16'hFFFF, 16'h0000));
      offer_request(pack_item(CMD_APPEND, 16'hFFFF, 16'h0000, 16'h0000));
      offer_request(pack_item(CMD_APPEND, 16'h0000, 16'hFFFF, 16'h0000));
      offer_request(pack_item(CMD_QUERY, 16'h0000, 16'h0000, 16'h0003));
      offer_request(pack_item(CMD_QUERY, 16'hFFFF, 16'h0000, 16'h0000));
      offer_request(pack_item(CMD_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF)); // ignored
      offer_request(pack_item(CMD_QUERY, 16'h8000, 16'h7FFF, 16'h0001));
      // straight chord: left of it, right of it, on it
      offer_request(pack_item(CMD_CLEAR, 16'h0000, 16'h0000, 16'h0000));
      for (k = 1; k <= 5; k++)
         offer_request(pack_item(CMD_APPEND, 16'(k * 10), 16'd10, 16'h0000));
      offer_request(pack_item(CMD_QUERY, 16'd30, 16'd20, 16'd2));
      offer_request(pack_item(CMD_QUERY, 16'd30, 16'd0, 16'd2));
      offer_request(pack_item(CMD_QUERY, 16'd30, 16'd10, 16'd0));
      // identical cells: ties push the minimum forward
      offer_request(pack_item(CMD_CLEAR, 16'h0000, 16'h0000, 16'h0000));
      for (k = 0; k < 3; k++)
         offer_request(pack_item(CMD_APPEND, 16'd100, 16'd100, 16'h0000));
      offer_request(pack_item(CMD_QUERY, 16'd100, 16'd100, 16'd0));
      offer_request(pack_item(CMD_CLEAR, 16'h0000, 16'h0000, 16'h0000));
      offer_request(pack_item(CMD_QUERY, 16'd5, 16'd5, 16'd0));
      drain_answers();
   endtask

   // fill the list past its depth; the first two queries walk its whole length
   task automatic test_full_list();
      int k;
      offer_request(pack_item(CMD_CLEAR, 16'h0000, 16'h0000, 16'h0000));
      for (k = 0; k < LIST_DEPTH + 2; k++)
         offer_request(pack_item(CMD_APPEND, 16'(k * 5), 16'(k * 3), 16'($urandom)));
      offer_request(pack_item(CMD_QUERY, 16'd0, 16'd0, 16'hFFFF));
      offer_request(pack_item(CMD_QUERY, 16'(1023 * 5), 16'(1023 * 3), 16'd0));
      offer_request(pack_item(CMD_QUERY, 16'(1024 * 5), 16'(1024 * 3), 16'd1023));
      offer_request(pack_item(CMD_QUERY, 16'd2500, 16'd1600, 16'd500));
      drain_answers();
   endtask

   task automatic test_random(input int item_goal);
      int          sent, len, queries, k;
      logic [15:0] x, y;
      req_type     item;
      sent = 0;
      while (sent < item_goal) begin
         if ($urandom_range(99) < 15) begin
            item.command    = 2'($urandom_range(3));
            item.cell_x     = 16'($urandom);
            item.cell_y     = 16'($urandom);
            item.hint_index = 16'($urandom);
            offer_request(item);
            if (item.command != CMD_UNUSED) sent++;
         end else begin
            offer_request(pack_item(CMD_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom)));
            len = ($urandom_range(99) < 2) ? $urandom_range(LIST_DEPTH, 100)
                                           : $urandom_range(40, 1);
            x = 16'($urandom);
            y = 16'($urandom);
            for (k = 0; k < len; k++) begin
               x = x + 16'($urandom_range(6)) - 16'd3;
               y = y + 16'($urandom_range(6)) - 16'd3;
               offer_request(pack_item(CMD_APPEND, x, y, 16'($urandom)));
            end
            queries = $urandom_range(12, 1);
            for (k = 0; k < queries; k++) offer_request(near_query());
            sent += 1 + len + queries;
         end
      end
   endtask

   // result side stalls long; queries pile up behind the one in work
   task automatic test_backpressure();
      int k;
      drain_answers();
      offer_request(pack_item(CMD_CLEAR, 16'h0000, 16'h0000, 16'h0000));
      for (k = 0; k < 20; k++)
         offer_request(pack_item(CMD_APPEND, 16'(k * 7), 16'(400 - k * 2), 16'h0000));
      hold_request = 1'b1;
      for (k = 0; k < 10; k++) offer_request(near_query());
      drain_answers();
   endtask

   initial begin
      send_idle_pct = 21;
      recv_idle_pct = 76;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_full_list();
      test_random(350);
      send_idle_pct = 76;
      recv_idle_pct = 21;
      test_random(350);
      test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(300);
      drain_answers();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_answers.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
